[rtl/pvrt_pkg.sv]
// Shared types, codes and constants for the path-vector route table.
`timescale 1ns / 1ps
package pvrt_pkg;

	localparam int DEF_MAX_ENTRIES = 16;

	// Operation codes
	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_ADD    = 3'd1;
	localparam logic [2:0] OP_UPDATE = 3'd2;
	localparam logic [2:0] OP_DEAD   = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd3;

	// Configuration register indexes
	localparam logic CFG_MY_ID = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic [2:0]  op;
		logic [3:0]  neighbor_id;
		logic [15:0] link_cost;
		logic [3:0]  route_dest;
		logic [15:0] adv_cost;
		logic [3:0]  adv_path_len;
		logic [63:0] adv_path;
	} item_t;

	typedef struct packed {
		logic        changed;
		logic [1:0]  status;
		logic [4:0]  num_routes;
		logic [3:0]  entry_dest;
		logic [3:0]  entry_next_hop;
		logic [15:0] entry_cost;
		logic [4:0]  entry_path_len;
		logic [63:0] entry_path;
	} result_t;

	typedef struct packed {
		logic [3:0]  dest;
		logic [3:0]  hop;
		logic [15:0] cost;
		logic [4:0]  plen;
		logic [63:0] path;
	} entry_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic idx_clr;
		logic rd;
		logic idx_inc;
		logic apply;
		logic done;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [2:0] op;
		logic       scan_end;
		logic       match;
		logic       out_free;
	} sts_t;

endpackage

[rtl/pvrt_dpath.sv]
// Datapath: config registers, route memory, scan index, update logic, result register.
`timescale 1ns / 1ps
module pvrt_dpath import pvrt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  item_t       in_data,
	input  cmd_t        cmd,
	output sts_t        sts,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_data
);

	localparam int AW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ENTRIES);

	logic [3:0]    my_id_q;
	logic [15:0]   limit_q;
	item_t         item_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [15:0]   dead_q;
	entry_t        mem [MAX_ENTRIES];
	entry_t        rd_q;
	result_t       res_q;
	result_t       out_q;
	logic          out_valid_q;

	logic [AW-1:0] rd_addr;
	logic          full;
	logic [16:0]   sum;
	logic [15:0]   sum_sat;
	logic [15:0]   forced;
	logic [63:0]   npath;
	logic [4:0]    nlen;
	logic          loop_hit;
	logic [15:0]   present;
	logic          dead_hit;
	logic          dest_dead;

	logic          we;
	logic [AW-1:0] waddr;
	entry_t        went;
	logic          cnt_inc;
	logic          chg;
	logic [1:0]    st;
	logic          capture;

	// Status back to the controller
	assign full     = (count_q == FULL_CNT);
	assign rd_addr  = (item_q.op == OP_READ) ? item_q.route_dest[AW-1:0] : idx_q[AW-1:0];
	assign sts.op   = item_q.op;
	assign sts.scan_end = (item_q.op == OP_READ) ?
		({1'b0, item_q.route_dest} >= 5'(count_q)) : (idx_q >= count_q);
	assign sts.match = (item_q.op == OP_UPDATE) ? (rd_q.dest == item_q.route_dest) :
		(rd_q.hop == item_q.neighbor_id);
	assign sts.out_free = !out_valid_q || out_ready;

	// Candidate route costs
	assign sum     = {1'b0, item_q.adv_cost} + {1'b0, item_q.link_cost};
	assign sum_sat = sum[16] ? 16'hFFFF : sum[15:0];
	assign forced  = (sum > {1'b0, limit_q}) ? limit_q : sum[15:0];
	assign nlen    = {1'b0, item_q.adv_path_len} + 5'd1;

	// Build new path and check it for my id and dead routers
	always_comb begin
		npath      = '0;
		npath[3:0] = my_id_q;
		loop_hit   = 1'b0;
		present    = '0;
		for (int k = 0; k < 15; k++) begin
			if (4'(k) < item_q.adv_path_len) begin
				npath[4*k+4 +: 4] = item_q.adv_path[4*k +: 4];
				if (item_q.adv_path[4*k +: 4] == my_id_q) begin
					loop_hit = 1'b1;
				end
				for (int j = 0; j < 16; j++) begin
					if (item_q.adv_path[4*k +: 4] == 4'(j)) begin
						present[j] = 1'b1;
					end
				end
			end
		end
	end

	assign dead_hit  = |(present & dead_q);
	assign dest_dead = dead_q[rd_q.dest];

	// Decide the table write and result flags for this step
	always_comb begin
		we      = 1'b0;
		waddr   = idx_q[AW-1:0];
		went    = rd_q;
		cnt_inc = 1'b0;
		chg     = 1'b0;
		st      = ST_OK;
		capture = 1'b0;
		if (cmd.apply) begin
			unique case (item_q.op)
				OP_CLEAR: begin
					we    = 1'b1;
					waddr = '0;
					went  = '{dest: my_id_q, hop: my_id_q, cost: 16'd0, plen: 5'd1,
						path: {60'd0, my_id_q}};
					chg   = 1'b1;
				end
				OP_ADD: begin
					if (full) begin
						st = ST_FULL;
					end else begin
						we      = 1'b1;
						waddr   = count_q[AW-1:0];
						went    = '{dest: item_q.neighbor_id, hop: item_q.neighbor_id,
							cost: item_q.link_cost, plen: 5'd2,
							path: {56'd0, item_q.neighbor_id, my_id_q}};
						cnt_inc = 1'b1;
						chg     = 1'b1;
					end
				end
				OP_UPDATE: begin
					if (sts.scan_end) begin
						if (full) begin
							st = ST_FULL;
						end else begin
							we      = 1'b1;
							waddr   = count_q[AW-1:0];
							went    = '{dest: item_q.route_dest, hop: item_q.neighbor_id,
								cost: sum_sat, plen: nlen, path: npath};
							cnt_inc = 1'b1;
							chg     = 1'b1;
						end
					end else if (!loop_hit) begin
						if ({1'b0, rd_q.cost} > sum) begin
							if (!(dead_hit || (dest_dead && rd_q.dest != item_q.neighbor_id)))
							begin
								we   = 1'b1;
								went = '{dest: rd_q.dest, hop: item_q.neighbor_id,
									cost: sum_sat, plen: nlen, path: npath};
								chg  = 1'b1;
							end
						end else if (rd_q.hop == item_q.neighbor_id) begin
							we        = 1'b1;
							went.cost = (forced > rd_q.cost) ? forced : rd_q.cost;
							went.plen = nlen;
							went.path = npath;
							chg       = (forced > rd_q.cost) || (rd_q.path != npath) ||
								(rd_q.plen != nlen);
						end
					end
				end
				OP_DEAD: begin
					if (!sts.scan_end && sts.match) begin
						we        = 1'b1;
						went.cost = limit_q;
						chg       = (rd_q.cost != limit_q);
					end
				end
				OP_READ: begin
					if (sts.scan_end) begin
						st = ST_RANGE;
					end else begin
						capture = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Route memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= went;
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Hold the accepted item and collect the result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			res_q  <= '0;
		end else if (cmd.apply) begin
			res_q.changed <= res_q.changed | chg;
			if (st != ST_OK) begin
				res_q.status <= st;
			end
			if (capture) begin
				res_q.entry_dest     <= rd_q.dest;
				res_q.entry_next_hop <= rd_q.hop;
				res_q.entry_cost     <= rd_q.cost;
				res_q.entry_path_len <= rd_q.plen;
				res_q.entry_path     <= rd_q.path;
			end
		end
		if (cmd.done) begin
			out_q            <= res_q;
			out_q.num_routes <= 5'(count_q);
		end
	end

	// Control state: config, count, scan index, dead marks, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id_q     <= '0;
			limit_q     <= 16'd999;
			count_q     <= '0;
			idx_q       <= '0;
			dead_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == CFG_MY_ID) begin
				my_id_q <= cfg_wdata[3:0];
			end
			if (cfg_we && cfg_index == CFG_LIMIT) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.apply && item_q.op == OP_CLEAR) begin
				count_q <= CW'(1);
				dead_q  <= '0;
			end else if (cnt_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
				if (item_q.op == OP_DEAD) begin
					dead_q[item_q.neighbor_id] <= 1'b1;
				end else if (item_q.op == OP_UPDATE) begin
					dead_q[item_q.neighbor_id] <= 1'b0;
				end
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end
			if (cmd.done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("route count above table depth");
	a_clear_one: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply && item_q.op == OP_CLEAR |=> count_q == CW'(1))
		else $error("clear did not leave one route");
	a_range_nochg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status == ST_RANGE |-> !out_q.changed)
		else $error("out-of-range read reported a change");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_inc |-> !full) else $error("append on full table");
`endif

endmodule

[rtl/pvrt_ctrl.sv]
// Controller: sequences one item through dispatch, table scan and result transfer.
`timescale 1ns / 1ps
module pvrt_ctrl import pvrt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_START = 5'b00010,
		S_RD    = 5'b00100,
		S_CHK   = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.load = in_valid && in_ready;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_START;
				end
			end
			S_START: begin
				priority if (sts.op == OP_UPDATE || sts.op == OP_DEAD) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_RD;
				end else if (sts.op == OP_READ) begin
					state_d = S_RD;
				end else begin
					cmd.apply = 1'b1;
					state_d   = S_FIN;
				end
			end
			S_RD: begin
				if (sts.scan_end) begin
					cmd.apply = 1'b1;
					state_d   = S_FIN;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				priority if (sts.op == OP_UPDATE) begin
					if (sts.match) begin
						cmd.apply = 1'b1;
						state_d   = S_FIN;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = S_RD;
					end
				end else if (sts.op == OP_DEAD) begin
					cmd.apply   = 1'b1;
					cmd.idx_inc = 1'b1;
					state_d     = S_RD;
				end else begin
					cmd.apply = 1'b1;
					state_d   = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/path_vector_route_table.sv]
// Top level of the path-vector route table: controller plus datapath.
//
// Usage: items arrive on in_valid/in_ready/in_data, one operation each
// (clear and self, add neighbor, route update, neighbor dead, read entry).
// Each item yields exactly one result on out_valid/out_ready/out_data.
// Configuration (my_id at index 0, cost_limit at index 1) is written through
// cfg_we/cfg_index/cfg_wdata; it takes effect at once. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Route update and neighbor dead scan the table one entry at a time through
// the single read port of the route memory.
// One item is in work at a time; in_ready rises again once its result sits in
// the output register, so the next item may start while that result waits.
// A stalled receiver holds the result; the controller waits in its final state
// only when a second result is ready before the first is taken.
// Reset clears the route count, dead marks and config (my_id 0, limit 999).
`timescale 1ns / 1ps
module path_vector_route_table import pvrt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_data
);

	cmd_t cmd;
	sts_t sts;

	pvrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pvrt_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

[bench/tb_path_vector_route_table.sv]
// Self-checking testbench for the path-vector route table.
`timescale 1ns / 1ps
module tb_path_vector_route_table;
	import pvrt_pkg::*;

	localparam int NENT = DEF_MAX_ENTRIES;
	localparam int CYCLE_LIMIT = 400000;

	// Holds expected results in order and counts mismatches
	class route_scoreboard;
		result_t pending[$];
		int errors;
		int checked;

		function new();
			errors = 0;
			checked = 0;
		endfunction

		function void note_item(result_t r);
			pending.push_back(r);
		endfunction

		function void check_result(result_t got);
			result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.changed !== e.changed) begin
				$error("changed exp %0d got %0d", e.changed, got.changed); errors++;
			end
			if (got.status !== e.status) begin
				$error("status exp %0d got %0d", e.status, got.status); errors++;
			end
			if (got.num_routes !== e.num_routes) begin
				$error("num_routes exp %0d got %0d", e.num_routes, got.num_routes); errors++;
			end
			if (got.entry_dest !== e.entry_dest) begin
				$error("entry_dest exp %0d got %0d", e.entry_dest, got.entry_dest); errors++;
			end
			if (got.entry_next_hop !== e.entry_next_hop) begin
				$error("entry_next_hop exp %0d got %0d", e.entry_next_hop,
					got.entry_next_hop); errors++;
			end
			if (got.entry_cost !== e.entry_cost) begin
				$error("entry_cost exp %0d got %0d", e.entry_cost, got.entry_cost); errors++;
			end
			if (got.entry_path_len !== e.entry_path_len) begin
				$error("entry_path_len exp %0d got %0d", e.entry_path_len,
					got.entry_path_len); errors++;
			end
			if (got.entry_path !== e.entry_path) begin
				$error("entry_path exp %h got %h", e.entry_path, got.entry_path); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	result_t out_data;

	path_vector_route_table i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: copy of the table and configuration
	logic [3:0]  tbl_dest [NENT];
	logic [3:0]  tbl_hop [NENT];
	logic [15:0] tbl_cost [NENT];
	logic [4:0]  tbl_plen [NENT];
	logic [63:0] tbl_path [NENT];
	logic [15:0] dead_mark;
	int          n_routes;
	logic [3:0]  self_id;
	logic [15:0] unreach_cost;

	route_scoreboard board;
	int cycles = 0;
	int n_sent = 0;
	int n_updates = 0;

	// Compute the result of one item and advance the table copy
	function automatic result_t route_outcome(item_t it);
		result_t r;
		logic [16:0] sum;
		logic [15:0] sat, t;
		logic [63:0] npath, mask;
		logic [4:0] nlen;
		logic [3:0] id, d;
		int idx;
		bit loop_hit, dead_hit;
		r = '0;
		idx = -1;
		loop_hit = 0;
		dead_hit = 0;
		case (it.op)
			OP_CLEAR: begin
				dead_mark = '0;
				tbl_dest[0] = self_id; tbl_hop[0] = self_id; tbl_cost[0] = '0;
				tbl_plen[0] = 5'd1; tbl_path[0] = {60'd0, self_id};
				n_routes = 1;
				r.changed = 1'b1;
			end
			OP_ADD: begin
				if (n_routes >= NENT) begin
					r.status = ST_FULL;
				end else begin
					tbl_dest[n_routes] = it.neighbor_id;
					tbl_hop[n_routes] = it.neighbor_id;
					tbl_cost[n_routes] = it.link_cost;
					tbl_plen[n_routes] = 5'd2;
					tbl_path[n_routes] = {56'd0, it.neighbor_id, self_id};
					n_routes++;
					r.changed = 1'b1;
				end
			end
			OP_UPDATE: begin
				sum = {1'b0, it.adv_cost} + {1'b0, it.link_cost};
				sat = sum[16] ? 16'hFFFF : sum[15:0];
				mask = (it.adv_path_len == 0) ? 64'd0
					: ((64'd1 << (4 * it.adv_path_len)) - 64'd1);
				npath = ((it.adv_path & mask) << 4) | {60'd0, self_id};
				nlen = {1'b0, it.adv_path_len} + 5'd1;
				dead_mark[it.neighbor_id] = 1'b0;
				for (int i = 0; i < n_routes; i++)
					if (idx < 0 && tbl_dest[i] == it.route_dest) idx = i;
				if (idx < 0) begin
					if (n_routes >= NENT) begin
						r.status = ST_FULL;
					end else begin
						tbl_dest[n_routes] = it.route_dest;
						tbl_hop[n_routes] = it.neighbor_id;
						tbl_cost[n_routes] = sat;
						tbl_plen[n_routes] = nlen;
						tbl_path[n_routes] = npath;
						n_routes++;
						r.changed = 1'b1;
					end
				end else begin
					for (int k = 0; k < it.adv_path_len; k++) begin
						id = it.adv_path[4*k +: 4];
						if (id == self_id) loop_hit = 1;
						if (dead_mark[id]) dead_hit = 1;
					end
					d = tbl_dest[idx];
					if (loop_hit) begin
						// reject looped path
					end else if ({1'b0, tbl_cost[idx]} > sum) begin
						if (!(dead_hit || (dead_mark[d] && d != it.neighbor_id))) begin
							tbl_hop[idx] = it.neighbor_id;
							tbl_cost[idx] = sat;
							tbl_plen[idx] = nlen;
							tbl_path[idx] = npath;
							r.changed = 1'b1;
						end
					end else if (tbl_hop[idx] == it.neighbor_id) begin
						t = ({1'b0, unreach_cost} < sum) ? unreach_cost : sum[15:0];
						if (t > tbl_cost[idx]) begin
							tbl_cost[idx] = t;
							r.changed = 1'b1;
						end
						if (tbl_path[idx] != npath || tbl_plen[idx] != nlen)
							r.changed = 1'b1;
						tbl_path[idx] = npath;
						tbl_plen[idx] = nlen;
					end
				end
			end
			OP_DEAD: begin
				dead_mark[it.neighbor_id] = 1'b1;
				for (int i = 0; i < n_routes; i++)
					if (tbl_hop[i] == it.neighbor_id) begin
						if (tbl_cost[i] != unreach_cost) r.changed = 1'b1;
						tbl_cost[i] = unreach_cost;
					end
			end
			OP_READ: begin
				if (it.route_dest >= n_routes) begin
					r.status = ST_RANGE;
				end else begin
					r.entry_dest = tbl_dest[it.route_dest];
					r.entry_next_hop = tbl_hop[it.route_dest];
					r.entry_cost = tbl_cost[it.route_dest];
					r.entry_path_len = tbl_plen[it.route_dest];
					r.entry_path = tbl_path[it.route_dest];
				end
			end
			default: ;
		endcase
		r.num_routes = n_routes[4:0];
		return r;
	endfunction

	// Drive one item and note its expectation on transfer
	task automatic send_item(item_t it);
		int gap;
		gap = $urandom_range(0, 9);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		board.note_item(route_outcome(it));
		if (it.op == OP_UPDATE) n_updates++;
		n_sent++;
	endtask

	// Wait for idle, then write one register
	task automatic write_reg(logic idx, logic [15:0] val);
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MY_ID) self_id = val[3:0];
		else unreach_cost = val;
	endtask

	function automatic item_t rand_item();
		item_t it;
		it.op = 3'($urandom_range(0, 7));
		it.neighbor_id = 4'($urandom);
		it.link_cost = 16'($urandom);
		it.route_dest = 4'($urandom);
		it.adv_cost = 16'($urandom);
		it.adv_path_len = 4'($urandom);
		it.adv_path = {$urandom, $urandom};
		return it;
	endfunction

	// Mostly well-formed traffic: small costs, valid reads, plausible paths
	function automatic item_t shaped_item();
		item_t it;
		int sel;
		it = rand_item();
		sel = $urandom_range(0, 99);
		if (sel < 3) it.op = OP_CLEAR;
		else if (sel < 15) it.op = OP_ADD;
		else if (sel < 60) it.op = OP_UPDATE;
		else if (sel < 70) it.op = OP_DEAD;
		else if (sel < 95) it.op = OP_READ;
		if ($urandom_range(0, 3) != 0) begin
			it.link_cost = 16'($urandom_range(0, 50));
			it.adv_cost = 16'($urandom_range(0, 200));
			it.adv_path_len = 4'($urandom_range(0, 5));
		end
		if (it.op == OP_READ && $urandom_range(0, 4) != 0)
			it.route_dest = 4'($urandom_range(0, (n_routes > 0) ? n_routes - 1 : 0));
		if ($urandom_range(0, 1)) it.route_dest[3] = 1'b0;
		return it;
	endfunction

	function automatic item_t mk(logic [2:0] op, logic [3:0] nb, logic [15:0] lc,
			logic [3:0] rd, logic [15:0] ac, logic [3:0] al, logic [63:0] ap);
		item_t it;
		it.op = op; it.neighbor_id = nb; it.link_cost = lc; it.route_dest = rd;
		it.adv_cost = ac; it.adv_path_len = al; it.adv_path = ap;
		return it;
	endfunction

	// Receiver: random stall, check on each transfer
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = $urandom_range(0, 9);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_result(out_data);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		board = new();
		dead_mark = '0;
		n_routes = 0;
		self_id = 4'd0;
		unreach_cost = 16'd999;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty reads, fill, overflow, loops, dead routers, forcing
		send_item(mk(OP_READ, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		send_item(mk(OP_ADD, 4'hF, 16'hFFFF, 0, 0, 0, 0));
		send_item(mk(OP_ADD, 4'd3, 16'd5, 0, 0, 0, 0));
		send_item(mk(OP_UPDATE, 4'd3, 16'hFFFF, 4'd9, 16'hFFFF, 4'hF, '1));
		send_item(mk(OP_UPDATE, 4'd3, 16'd1, 4'd9, 16'd1, 4'd2, 64'h57));
		send_item(mk(OP_UPDATE, 4'd2, 16'd0, 4'd9, 16'd0, 4'd2, 64'h50));
		send_item(mk(OP_UPDATE, 4'd2, 16'd500, 4'd9, 16'd700, 4'd1, 64'h8));
		send_item(mk(OP_UPDATE, 4'd2, 16'd500, 4'd9, 16'd700, 4'd1, 64'h8));
		send_item(mk(OP_DEAD, 4'd2, 0, 0, 0, 0, 0));
		send_item(mk(OP_DEAD, 4'd2, 0, 0, 0, 0, 0));
		send_item(mk(OP_UPDATE, 4'd3, 16'd0, 4'd9, 16'd0, 4'd2, 64'h24));
		send_item(mk(OP_READ, 0, 0, 4'd3, 0, 0, 0));
		send_item(mk(OP_READ, 0, 0, 4'hF, 0, 0, 0));
		send_item(mk(3'd5, 0, 0, 0, 0, 0, 0));
		send_item(mk(3'd7, '1, '1, '1, '1, '1, '1));
		for (int i = 0; i < 15; i++)
			send_item(mk(OP_ADD, 4'(i), 16'(i), 0, 0, 0, 0));
		send_item(mk(OP_UPDATE, 4'd1, 16'd1, 4'hE, 16'd1, 4'd0, 0));
		for (int i = 0; i < 16; i++)
			send_item(mk(OP_READ, 0, 0, 4'(i), 0, 0, 0));

		// Random phases under different configurations
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_reg(CFG_MY_ID, 16'd15); write_reg(CFG_LIMIT, 16'd1); end
				1: begin write_reg(CFG_MY_ID, 16'd7); write_reg(CFG_LIMIT, 16'hFFFF); end
				2: begin write_reg(CFG_MY_ID, 16'd0); write_reg(CFG_LIMIT, 16'd100); end
				3: begin
					write_reg(CFG_MY_ID, 16'($urandom));
					write_reg(CFG_LIMIT, 16'($urandom_range(1, 65535)));
				end
				default: write_reg(CFG_LIMIT, 16'd999);
			endcase
			send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));
			for (int j = 0; j < 105; j++)
				send_item(($urandom_range(0, 9) == 0) ? rand_item() : shaped_item());
		end
		in_valid <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d items (%0d route updates), checked %0d results,",
			n_sent, n_updates, board.checked);
		$display("over five register settings including both cost limit extremes.");
		if (board.errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
